>>> hw/rtl/sorted_priority_queue_top_macros.svh
// Assertion helpers for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define SPQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define SPQ_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define SPQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

   localparam int PRIO_W = 32;
   localparam int TAG_W  = 16;
   localparam int OCC_W  = 5;
   localparam int CODE_W = 2;

   localparam logic REQ_INSERT  = 1'b0;
   localparam logic REQ_EXTRACT = 1'b1;

   localparam logic [CODE_W-1:0] ST_DONE  = 2'd0;
   localparam logic [CODE_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [CODE_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                     req_type;
      logic signed [PRIO_W-1:0] priority_req;
      logic        [TAG_W-1:0]  tag;
   } req_word_type;

   typedef struct packed {
      logic [TAG_W-1:0]  out_tag;
      logic [CODE_W-1:0] status;
      logic [OCC_W-1:0]  occupancy;
   } rsp_word_type;

   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic        [TAG_W-1:0]  tag;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_EXT_RD,
      S_EXT_DATA,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic rd_head;
      logic rd_idx;
      logic wr_new;
      logic wr_moved;
      logic dec_idx;
      logic take_head;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic idx_zero;
      logic prio_ge;
   } dp_stat_type;

endpackage

>>> hw/rtl/spq_datapath.sv
`timescale 1ns / 1ps
module spq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spq_pkg::req_word_type req_word,
   input  spq_pkg::cmd_type     cmd,
   output spq_pkg::dp_stat_type stat,
   output spq_pkg::rsp_word_type rsp_word
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   spq_pkg::entry_type mem [DEPTH];
   spq_pkg::entry_type rd_ff;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff;
   spq_pkg::entry_type new_ff;
   logic [spq_pkg::CODE_W-1:0] code_ff;
   logic [spq_pkg::TAG_W-1:0]  tag_ff;
   spq_pkg::rsp_word_type      rsp_ff;

   logic [SW-1:0] wr_sum, wr_wrap, rd_sum, rd_wrap;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_en;
   spq_pkg::entry_type wr_data;
   logic [spq_pkg::CODE_W-1:0] code_in;

   // Slots are kept in a ring: logical slot i lives at head + i.
   always_comb begin
      wr_sum  = SW'(head_ff) + SW'(idx_ff);
      wr_wrap = (wr_sum >= SW'(DEPTH)) ? wr_sum - SW'(DEPTH) : wr_sum;
      wr_addr = wr_wrap[AW-1:0];
      rd_sum  = cmd.rd_head ? SW'(head_ff) : SW'(head_ff) + SW'(idx_ff) - SW'(1);
      rd_wrap = (rd_sum >= SW'(DEPTH)) ? rd_sum - SW'(DEPTH) : rd_sum;
      rd_addr = rd_wrap[AW-1:0];
      wr_en   = cmd.wr_new | cmd.wr_moved;
      wr_data = cmd.wr_new ? new_ff : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_head | cmd.rd_idx) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      stat.empty    = (count_ff == '0);
      stat.full     = (count_ff == CW'(DEPTH));
      stat.idx_zero = (idx_ff == '0);
      stat.prio_ge  = ($signed(rd_ff.prio) >= $signed(new_ff.prio));
   end

   always_comb begin
      code_in = spq_pkg::ST_DONE;
      if (req_word.req_type == spq_pkg::REQ_INSERT && stat.full) begin
         code_in = spq_pkg::ST_FULL;
      end else if (req_word.req_type == spq_pkg::REQ_EXTRACT && stat.empty) begin
         code_in = spq_pkg::ST_EMPTY;
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.take_head) begin
         head_in  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
         count_in = count_ff - CW'(1);
      end else if (cmd.wr_new) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         new_ff.prio <= req_word.priority_req;
         new_ff.tag  <= req_word.tag;
         idx_ff      <= count_ff;
         code_ff     <= code_in;
         tag_ff      <= '0;
      end else begin
         if (cmd.dec_idx) begin
            idx_ff <= idx_ff - CW'(1);
         end
         if (cmd.take_head) begin
            tag_ff <= rd_ff.tag;
         end
      end
      if (cmd.load_rsp) begin
         rsp_ff.out_tag   <= tag_ff;
         rsp_ff.status    <= code_ff;
         rsp_ff.occupancy <= spq_pkg::OCC_W'(count_ff);
      end
   end

   assign rsp_word = rsp_ff;

endmodule

>>> hw/rtl/spq_ctrl.sv
`timescale 1ns / 1ps
module spq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_is_extract,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  spq_pkg::dp_stat_type stat,
   output spq_pkg::cmd_type     cmd
);

   spq_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   assign rsp_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spq_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_is_extract) begin
                  state_in = stat.empty ? spq_pkg::S_FINISH : spq_pkg::S_EXT_RD;
               end else begin
                  state_in = stat.full ? spq_pkg::S_FINISH : spq_pkg::S_INS_RD;
               end
            end
         end
         spq_pkg::S_INS_RD: begin
            state_in = stat.idx_zero ? spq_pkg::S_FINISH : spq_pkg::S_INS_CMP;
         end
         spq_pkg::S_INS_CMP: begin
            state_in = stat.prio_ge ? spq_pkg::S_FINISH : spq_pkg::S_INS_RD;
         end
         spq_pkg::S_EXT_RD: begin
            state_in = spq_pkg::S_EXT_DATA;
         end
         spq_pkg::S_EXT_DATA: begin
            state_in = spq_pkg::S_FINISH;
         end
         spq_pkg::S_FINISH: begin
            if (rsp_free) begin
               state_in = spq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         spq_pkg::S_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         spq_pkg::S_INS_RD: begin
            // At the top of the list: drop the new word into the free slot.
            cmd.wr_new = stat.idx_zero;
            cmd.rd_idx = ~stat.idx_zero;
         end
         spq_pkg::S_INS_CMP: begin
            // Stop behind an equal or higher priority, else move that word down.
            cmd.wr_new   = stat.prio_ge;
            cmd.wr_moved = ~stat.prio_ge;
            cmd.dec_idx  = ~stat.prio_ge;
         end
         spq_pkg::S_EXT_RD: begin
            cmd.rd_head = 1'b1;
         end
         spq_pkg::S_EXT_DATA: begin
            cmd.take_head = 1'b1;
         end
         spq_pkg::S_FINISH: begin
            cmd.load_rsp = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/sorted_priority_queue_top.sv
// Bounded max-priority queue of DEPTH entries held in one memory as a ring
// kept in priority order. An insert word places its entry behind every stored
// entry of equal or higher priority (equal priorities leave first-in
// first-out); an extract word removes the front entry and returns its tag.
// Each request gives one response word with the tag (zero unless an entry was
// extracted), a status (done, extract from empty, insert dropped because full)
// and the occupancy after the request. An extract reads the front entry and then
// takes it off. An insert walks the ring from the back, one read and one write
// of the memory per stored entry of lower priority that it passes; a dropped
// insert or an empty extract goes straight to its response. One request is
// worked on at a time; a new request is taken while the previous response
// still waits on rsp_stall. No clearing pass runs after reset.
`timescale 1ns / 1ps
`include "sorted_priority_queue_top_macros.svh"
module sorted_priority_queue_top #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spq_pkg::rsp_word_type rsp_word
);

   spq_pkg::cmd_type     dp_cmd;
   spq_pkg::dp_stat_type dp_stat;

   spq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_is_extract (req_word.req_type == spq_pkg::REQ_EXTRACT),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .stat           (dp_stat),
      .cmd            (dp_cmd)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (dp_cmd),
      .stat     (dp_stat),
      .rsp_word (rsp_word)
   );

   `SPQ_ASSERT_IMPLY(a_no_write_while_open, clock, reset, !req_stall, !(dp_cmd.wr_new || dp_cmd.wr_moved), "memory written while taking requests")
   `SPQ_ASSERT_IMPLY(a_full_occupancy, clock, reset, rsp_valid && rsp_word.status == spq_pkg::ST_FULL, rsp_word.occupancy == spq_pkg::OCC_W'(DEPTH) && rsp_word.out_tag == '0, "dropped insert with wrong occupancy")
   `SPQ_ASSERT_IMPLY(a_empty_extract, clock, reset, rsp_valid && rsp_word.status == spq_pkg::ST_EMPTY, rsp_word.occupancy == '0 && rsp_word.out_tag == '0, "empty extract with stored entries")
   `SPQ_ASSERT_ALWAYS(a_not_full_and_empty, clock, reset, !(dp_stat.full && dp_stat.empty), "count both full and empty")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int DEPTH       = 16;
   localparam int TOTAL_ITEMS = 1850;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 60;

   typedef struct packed {
      spq_pkg::req_word_type word;
      logic                  drain;
   } pending_req_type;

   typedef enum {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;
   typedef enum {PRIO_WIDE, PRIO_NARROW, PRIO_EXTREME, PRIO_MIXED} prio_style_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   spq_pkg::req_word_type req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   spq_pkg::rsp_word_type rsp_word;

   // queue contents as they should stand, highest priority in slot 0
   logic signed [spq_pkg::PRIO_W-1:0] ordered_prio [DEPTH];
   logic        [spq_pkg::TAG_W-1:0]  ordered_tag  [DEPTH];
   int                                stored_count = 0;

   pending_req_type       pending_reqs[$];
   spq_pkg::rsp_word_type expected_rsp[$];

   int req_taken    = 0;
   int words_sent   = 0;
   int gap_left     = 0;
   int burst_left   = 1;
   int error_count  = 0;
   int cycle_count  = 0;
   int stall_hold   = 0;
   int stall_phase  = 0;
   stall_mode_type stall_mode = STALL_NONE;

   sorted_priority_queue_top #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Update the expected queue contents and return the response word.
   function automatic spq_pkg::rsp_word_type apply_request(input spq_pkg::req_word_type w);
      spq_pkg::rsp_word_type             r;
      logic signed [spq_pkg::PRIO_W-1:0] new_prio;
      int                                slot;
      int                                i;
      r        = '0;
      r.status = spq_pkg::ST_DONE;
      new_prio = w.priority_req;
      if (w.req_type == spq_pkg::REQ_INSERT) begin
         if (stored_count >= DEPTH) begin
            r.status = spq_pkg::ST_FULL;
         end else begin
            slot = 0;
            while (slot < stored_count && ordered_prio[slot] >= new_prio)
               slot++;
            for (i = stored_count; i > slot; i--) begin
               ordered_prio[i] = ordered_prio[i-1];
               ordered_tag[i]  = ordered_tag[i-1];
            end
            ordered_prio[slot] = new_prio;
            ordered_tag[slot]  = w.tag;
            stored_count++;
         end
      end else begin
         if (stored_count == 0) begin
            r.status = spq_pkg::ST_EMPTY;
         end else begin
            r.out_tag = ordered_tag[0];
            for (i = 0; i + 1 < stored_count; i++) begin
               ordered_prio[i] = ordered_prio[i+1];
               ordered_tag[i]  = ordered_tag[i+1];
            end
            stored_count--;
         end
      end
      r.occupancy = stored_count[spq_pkg::OCC_W-1:0];
      return r;
   endfunction

   task automatic queue_word(input logic kind, input logic [spq_pkg::PRIO_W-1:0] prio,
                             input logic [spq_pkg::TAG_W-1:0] tag_val, input logic drain);
      pending_req_type p;
      p.word.req_type     = kind;
      p.word.priority_req = prio;
      p.word.tag          = tag_val;
      p.drain             = drain;
      pending_reqs.push_back(p);
   endtask

   function automatic logic [spq_pkg::TAG_W-1:0] pick_tag();
      return spq_pkg::TAG_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [spq_pkg::PRIO_W-1:0] pick_priority(input prio_style_type style);
      prio_style_type s;
      s = style;
      if (s == PRIO_MIXED)
         s = prio_style_type'($urandom_range(0, 2));
      case (s)
         PRIO_NARROW: return $urandom_range(0, 7) - 4;
         PRIO_EXTREME: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               3: return 32'hffff_ffff;
               default: return 32'h0000_0001;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int             i;
      int             phase_len;
      int             insert_pct;
      logic           drain;
      prio_style_type style;

      // directed: empty extract, extremes, equal priorities, fill, overflow, five extracts
      queue_word(spq_pkg::REQ_EXTRACT, 32'h7fff_ffff, 16'hffff, 1'b0);
      queue_word(spq_pkg::REQ_INSERT, 32'h7fff_ffff, 16'hffff, 1'b0);
      queue_word(spq_pkg::REQ_INSERT, 32'h8000_0000, 16'h0000, 1'b0);
      queue_word(spq_pkg::REQ_INSERT, 32'd5, 16'h0001, 1'b0);
      queue_word(spq_pkg::REQ_INSERT, 32'd5, 16'h0002, 1'b0);
      queue_word(spq_pkg::REQ_INSERT, 32'hffff_ffff, 16'ha5a5, 1'b0);
      for (i = 0; i < 11; i++)
         queue_word(spq_pkg::REQ_INSERT, spq_pkg::PRIO_W'((i % 4) + 3),
                    spq_pkg::TAG_W'(32'h0100 + i), 1'b0);
      queue_word(spq_pkg::REQ_INSERT, 32'h7fff_ffff, 16'h1234, 1'b0);
      for (i = 0; i < 5; i++)
         queue_word(spq_pkg::REQ_EXTRACT, $urandom, pick_tag(), 1'b0);

      while (pending_reqs.size() < TOTAL_ITEMS) begin
         phase_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: insert_pct = 25;
            1: insert_pct = 50;
            default: insert_pct = 80;
         endcase
         style = prio_style_type'($urandom_range(0, 3));
         drain = (pending_reqs.size() < 30) || ($urandom_range(0, 3) == 0);
         for (i = 0; i < phase_len; i++) begin
            if ($urandom_range(0, 99) < insert_pct)
               queue_word(spq_pkg::REQ_INSERT, pick_priority(style), pick_tag(),
                          drain && i == 0);
            else
               queue_word(spq_pkg::REQ_EXTRACT, $urandom, pick_tag(), drain && i == 0);
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_taken != words_sent || expected_rsp.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_rsp.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // sender: bursts of words with random gaps, hold a word until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_taken != words_sent)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0 &&
                      !(pending_reqs[0].drain && expected_rsp.size() > 0)) begin
            req_word  <= pending_reqs[0].word;
            req_valid <= 1'b1;
            void'(pending_reqs.pop_front());
            words_sent++;
            burst_left--;
            if (burst_left <= 0) begin
               if ($urandom_range(0, 5) == 0) begin
                  burst_left = $urandom_range(50, 200);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, switched between modes now and then
   always @(negedge clock) begin
      if (stall_hold == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_hold = $urandom_range(50, 300);
      end
      stall_hold--;
      stall_phase++;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_SPARSE:   rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_PERIODIC: rsp_stall <= ((stall_phase % 8) < 3);
         default:        rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      spq_pkg::rsp_word_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected response word: tag %h status %0d occupancy %0d",
                           rsp_word.out_tag, rsp_word.status, rsp_word.occupancy);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_word.out_tag !== want.out_tag || rsp_word.status !== want.status ||
                   rsp_word.occupancy !== want.occupancy) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("mismatch: expected tag %h status %0d occupancy %0d",
                              want.out_tag, want.status, want.occupancy);
                     $display("          got tag %h status %0d occupancy %0d",
                              rsp_word.out_tag, rsp_word.status, rsp_word.occupancy);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(apply_request(req_word));
            req_taken++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
